// ===== design/matrix4x4_arith_unit_core_assert.svh =====
// assertion macros used by the core design file
`ifndef MATRIX4X4_ARITH_UNIT_CORE_ASSERT_SVH
`define MATRIX4X4_ARITH_UNIT_CORE_ASSERT_SVH

// same-cycle implication, switched off while reset is high
`define M4AU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m4au assertion failed");

// next-cycle implication, switched off while reset is high
`define M4AU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m4au assertion failed");

`endif

// ===== design/m4au_pkg.sv =====
`default_nettype none

package m4au_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int CELLS     = DIM * DIM;
   localparam int IDX_W     = 4;
   localparam int K_W       = $clog2(DIM);
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + K_W + 1;

   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_MUL = 2'd0,
      MODE_ADD = 2'd1,
      MODE_SUB = 2'd2
   } op_mode_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } m4au_wr_type;

endpackage

`default_nettype wire

// ===== design/m4au_req_if.sv =====
`default_nettype none

interface m4au_req_if;
   import m4au_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic [IDX_W-1:0]         elem_index;
   logic signed [DATA_W-1:0] elem_value;

   modport source (output valid, req_type, elem_index, elem_value, input ready);
   modport sink (input valid, req_type, elem_index, elem_value, output ready);
endinterface

`default_nettype wire

// ===== design/m4au_rsp_if.sv =====
`default_nettype none

interface m4au_rsp_if;
   import m4au_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         result_index;
   logic signed [DATA_W-1:0] result_value;
   logic                     last_result;

   modport source (output valid, result_index, result_value, last_result, input ready);
   modport sink (input valid, result_index, result_value, last_result, output ready);
endinterface

`default_nettype wire

// ===== design/m4au_store.sv =====
`default_nettype none

module m4au_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire m4au_pkg::m4au_wr_type         wr,
   input  wire logic [m4au_pkg::IDX_W-1:0]    rd_addr,
   output logic signed [m4au_pkg::DATA_W-1:0] rd_data
);
   import m4au_pkg::*;

   logic [DATA_W-1:0] mem_ff [CELLS];
   logic [CELLS-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // entries never written read back as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
   end

   assign rd_data = signed'(rd_data_ff);
endmodule

`default_nettype wire

// ===== design/matrix4x4_arith_unit_core.sv =====
// 4x4 signed Q16.16 matrix unit: A times B, A plus B or A minus B, 16 items per compute.
// loads: one cycle each, taken back to back while the fsm is idle.
// multiply: each term steps through read, multiply and accumulate on the one shared 32x32
// multiplier and accumulator; after the fourth term the sum is scaled and saturated.
// add/sub: not ready from compute accept to the last result taken.
// synchronous active-high reset clears both stores to zero, op_mode to multiply, fsm idle.
`default_nettype none
`include "matrix4x4_arith_unit_core_assert.svh"

module matrix4x4_arith_unit_core (
   input  wire logic       clock,
   input  wire logic       reset,
   m4au_req_if.sink        req,
   m4au_rsp_if.source      rsp,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);
   import m4au_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_ACC,
      S_ADD,
      S_SAT,
      S_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [1:0]               op_mode_ff;
   logic [IDX_W-1:0]         elem_ff, elem_in;
   logic [K_W-1:0]           k_ff, k_in;
   logic signed [PROD_W-1:0] product_ff, product_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   m4au_wr_type              wr_a, wr_b;
   logic [IDX_W-1:0]         a_addr, b_addr;
   logic signed [DATA_W-1:0] a_data, b_data;
   logic signed [ACC_W-1:0]  scaled;
   logic                     req_fire;
   logic                     mul_mode;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DATA_W:0] upper;
      upper = v[ACC_W-1:DATA_W-1];
      if ((upper == '0) || (upper == '1)) begin
         return v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign mul_mode  = (op_mode_ff == MODE_MUL);

   always_comb begin
      wr_a.en   = req_fire && (req.req_type == REQ_LOAD_A) && (int'(req.elem_index) < CELLS);
      wr_a.addr = req.elem_index;
      wr_a.data = req.elem_value;
      wr_b.en   = req_fire && (req.req_type == REQ_LOAD_B) && (int'(req.elem_index) < CELLS);
      wr_b.addr = req.elem_index;
      wr_b.data = req.elem_value;
   end

   // product walks row of A and column of B, element-wise modes read the same cell
   always_comb begin
      if (mul_mode) begin
         a_addr = IDX_W'(int'(elem_ff) / DIM * DIM + int'(k_ff));
         b_addr = IDX_W'(int'(k_ff) * DIM + int'(elem_ff) % DIM);
      end else begin
         a_addr = elem_ff;
         b_addr = elem_ff;
      end
   end

   m4au_store u_store_a (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr_a),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   m4au_store u_store_b (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr_b),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   assign scaled = mul_mode ? (acc_ff >>> FRAC_BITS) : acc_ff;

   always_comb begin
      state_in     = state_ff;
      elem_in      = elem_ff;
      k_in         = k_ff;
      product_in   = product_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req.req_type == REQ_COMPUTE)) begin
               elem_in  = '0;
               k_in     = '0;
               acc_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = mul_mode ? S_MUL : S_ADD;
         end
         S_MUL: begin
            product_in = a_data * b_data;
            state_in   = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + ACC_W'(product_ff);
            if (k_ff == K_W'(DIM - 1)) begin
               state_in = S_SAT;
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = S_READ;
            end
         end
         S_ADD: begin
            if (op_mode_ff == MODE_ADD) begin
               acc_in = ACC_W'(a_data) + ACC_W'(b_data);
            end else if (op_mode_ff == MODE_SUB) begin
               acc_in = ACC_W'(a_data) - ACC_W'(b_data);
            end else begin
               acc_in = '0;
            end
            state_in = S_SAT;
         end
         S_SAT: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = elem_ff;
            rsp_value_in = sat32(scaled);
            rsp_last_in  = (elem_ff == IDX_W'(CELLS - 1));
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               k_in         = '0;
               acc_in       = '0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  elem_in  = elem_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_mode_ff   <= MODE_MUL;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            op_mode_ff <= csr_wr_data;
         end
      end
      elem_ff      <= elem_in;
      k_ff         <= k_in;
      product_ff   <= product_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_index = rsp_index_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.last_result  = rsp_last_ff;

   `M4AU_ASSERT_NOW(a_busy_while_rsp, clock, reset, rsp_valid_ff, !req.ready)
   `M4AU_ASSERT_NOW(a_last_index, clock, reset, rsp_valid_ff && rsp_last_ff,
                    rsp_index_ff == IDX_W'(CELLS - 1))
   `M4AU_ASSERT_NEXT(a_idle_after_last, clock, reset,
                     rsp.valid && rsp.ready && rsp_last_ff, req.ready)
   `M4AU_ASSERT_NEXT(a_step_after_rsp, clock, reset,
                     rsp.valid && rsp.ready && !rsp_last_ff,
                     (state_ff == S_READ) && (elem_ff == $past(elem_ff) + IDX_W'(1)))
endmodule

`default_nettype wire
